@@ sv/circular_wall_reflection_unit_defines.svh @@
// Assertion macros for the circular wall reflection unit.
// Taken in by the top level; needs clk and rst_n in the scope of each use.
`ifndef CIRCULAR_WALL_REFLECTION_UNIT_DEFINES_SVH
`define CIRCULAR_WALL_REFLECTION_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CWR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cwr: same-cycle check failed");
`define CWR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cwr: next-cycle check failed");
`else
`define CWR_ASSERT_IMPL(label, ante, cons)
`define CWR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ sv/cwr_pkg.sv @@
// Shared types, widths and arithmetic helpers of the circular wall reflection unit.
// No dependencies; used by every module of the block.
`default_nettype none
package cwr_pkg;

  localparam int DW      = 32;           // data width of every position and velocity field
  localparam int FB      = 16;           // fraction bits
  localparam int RAD_W   = DW - 1;       // radius register width
  localparam int DIFF_W  = DW + 1;       // offset from the centre
  localparam int SQ_W    = 2 * DIFF_W;   // squared distance
  localparam int ROOT_W  = DIFF_W;       // integer square root
  localparam int REM_W   = ROOT_W + 2;   // square root remainder
  localparam int SQ_PER  = 3;            // root bits per stage
  localparam int SQ_STAGES = ROOT_W / SQ_PER;
  localparam int NRM_W   = FB + 1;       // normal magnitude, up to 1.0
  localparam int NQ_BITS = FB + 2;       // quotient bits incl. rounding bit
  localparam int ND_PER  = 3;            // quotient bits per stage
  localparam int ND_STAGES = NQ_BITS / ND_PER;
  localparam int PROD_W  = DIFF_W + 1 + NRM_W;
  localparam int TERM_W  = PROD_W - FB;  // rounded product magnitude
  localparam int ACC_W   = TERM_W + 2;   // pre-saturation sums
  localparam int CFG_IDX_W = 2;

  typedef logic signed [DW-1:0]     dw_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic [SQ_W-1:0]          sq_t;
  typedef logic [ROOT_W-1:0]        root_t;
  typedef logic [REM_W-1:0]         rem_t;
  typedef logic [NRM_W-1:0]         nrm_t;
  typedef logic [NQ_BITS-1:0]       nq_t;
  typedef logic [PROD_W-1:0]        prod_t;
  typedef logic signed [TERM_W:0]   term_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WALL_RADIUS   = 2'd0,
    CFG_WALL_CENTER_X = 2'd1,
    CFG_WALL_CENTER_Y = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    dw_t pos_x;
    dw_t pos_y;
    dw_t vel_x;
    dw_t vel_y;
  } in_t;

  typedef struct packed {
    dw_t  new_pos_x;
    dw_t  new_pos_y;
    dw_t  new_vel_x;
    dw_t  new_vel_y;
    logic hit_wall;
  } out_t;

  // Request context that rides along the pipeline.
  typedef struct packed {
    in_t   data;
    diff_t dx;
    diff_t dy;
    logic  hit;
    root_t ovl;
  } side_t;

  localparam nrm_t  NRM_ONE  = nrm_t'(1) << FB;
  localparam prod_t HALF_LSB = prod_t'(1) << (FB - 1);
  localparam dw_t   DW_MAX   = {1'b0, {(DW - 1){1'b1}}};
  localparam dw_t   DW_MIN   = {1'b1, {(DW - 1){1'b0}}};

  function automatic logic [DW-1:0] mag_dw(dw_t v);
    return v[DW-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic root_t mag_diff(diff_t v);
    return v[DIFF_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [ACC_W-1:0] mag_acc(acc_t v);
    return v[ACC_W-1] ? (~v + 1'b1) : v;
  endfunction

  // Shift a product magnitude down by FB, round half away from zero, apply sign.
  function automatic term_t rnd_term(prod_t p, logic neg);
    prod_t s;
    term_t t;
    s = p + HALF_LSB;
    t = {1'b0, s[PROD_W-1:FB]};
    return neg ? -t : t;
  endfunction

  function automatic dw_t sat_dw(acc_t v);
    logic [ACC_W-DW:0] top;
    top = v[ACC_W-1:DW-1];
    if ((&top) || !(|top)) return v[DW-1:0];
    return v[ACC_W-1] ? DW_MIN : DW_MAX;
  endfunction

endpackage
`default_nettype wire

@@ sv/cwr_isqrt.sv @@
// Pipelined integer square root, SQ_PER result bits per stage, request context alongside.
// Depends on cwr_pkg.
`default_nettype none
module cwr_isqrt (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  v_i,
  input  cwr_pkg::sq_t          rad_i,
  input  cwr_pkg::side_t        side_i,
  output logic                  v_o,
  output cwr_pkg::root_t        root_o,
  output cwr_pkg::side_t        side_o
);

  typedef struct packed {
    cwr_pkg::sq_t   rad;
    cwr_pkg::rem_t  rem;
    cwr_pkg::root_t root;
  } sq_stage_t;

  function automatic sq_stage_t sq_stage(sq_stage_t a);
    sq_stage_t b;
    logic [cwr_pkg::REM_W+1:0] t;
    logic [cwr_pkg::REM_W+1:0] trial;
    logic [cwr_pkg::REM_W+1:0] diff;
    b = a;
    for (int j = 0; j < cwr_pkg::SQ_PER; j++) begin
      t     = {b.rem, b.rad[cwr_pkg::SQ_W-1 -: 2]};
      trial = {{(cwr_pkg::REM_W - cwr_pkg::ROOT_W){1'b0}}, b.root, 2'b01};
      diff  = t - trial;
      if (t >= trial) begin
        b.rem  = diff[cwr_pkg::REM_W-1:0];
        b.root = {b.root[cwr_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        b.rem  = t[cwr_pkg::REM_W-1:0];
        b.root = {b.root[cwr_pkg::ROOT_W-2:0], 1'b0};
      end
      b.rad = {b.rad[cwr_pkg::SQ_W-3:0], 2'b00};
    end
    return b;
  endfunction

  logic           v_r    [cwr_pkg::SQ_STAGES];
  sq_stage_t      st_r   [cwr_pkg::SQ_STAGES];
  cwr_pkg::side_t side_r [cwr_pkg::SQ_STAGES];
  sq_stage_t      st_nxt [cwr_pkg::SQ_STAGES];
  sq_stage_t      st_in0;

  assign st_in0 = '{rad: rad_i, rem: '0, root: '0};

  always_comb begin
    st_nxt[0] = sq_stage(st_in0);
    for (int s = 1; s < cwr_pkg::SQ_STAGES; s++) begin
      st_nxt[s] = sq_stage(st_r[s-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < cwr_pkg::SQ_STAGES; s++) v_r[s] <= 1'b0;
    end else if (en) begin
      v_r[0] <= v_i;
      for (int s = 1; s < cwr_pkg::SQ_STAGES; s++) v_r[s] <= v_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_i;
      for (int s = 1; s < cwr_pkg::SQ_STAGES; s++) side_r[s] <= side_r[s-1];
      for (int s = 0; s < cwr_pkg::SQ_STAGES; s++) st_r[s] <= st_nxt[s];
    end
  end

  assign v_o    = v_r[cwr_pkg::SQ_STAGES-1];
  assign root_o = st_r[cwr_pkg::SQ_STAGES-1].root;
  assign side_o = side_r[cwr_pkg::SQ_STAGES-1];

endmodule
`default_nettype wire

@@ sv/cwr_ndiv.sv @@
// Pipelined divider for both unit normal components, ND_PER quotient bits per stage.
// Depends on cwr_pkg.
`default_nettype none
module cwr_ndiv (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  v_i,
  input  cwr_pkg::root_t        den_i,
  input  cwr_pkg::side_t        side_i,
  output logic                  v_o,
  output cwr_pkg::nrm_t         nxm_o,
  output cwr_pkg::nrm_t         nym_o,
  output cwr_pkg::side_t        side_o
);

  typedef struct packed {
    cwr_pkg::root_t den;
    cwr_pkg::root_t rx;
    cwr_pkg::root_t ry;
    cwr_pkg::nq_t   qx;
    cwr_pkg::nq_t   qy;
  } nd_stage_t;

  // One restoring step; the very first step compares without a shift.
  function automatic logic [cwr_pkg::ROOT_W:0] div_bit(cwr_pkg::root_t r,
                                                       cwr_pkg::root_t den,
                                                       logic first);
    logic [cwr_pkg::ROOT_W:0] t;
    logic [cwr_pkg::ROOT_W:0] diff;
    t    = first ? {1'b0, r} : {r, 1'b0};
    diff = t - {1'b0, den};
    if (t >= {1'b0, den}) return {1'b1, diff[cwr_pkg::ROOT_W-1:0]};
    return {1'b0, t[cwr_pkg::ROOT_W-1:0]};
  endfunction

  function automatic nd_stage_t nd_stage(nd_stage_t a, logic first_stage);
    nd_stage_t b;
    logic [cwr_pkg::ROOT_W:0] bx;
    logic [cwr_pkg::ROOT_W:0] by;
    logic f;
    b = a;
    for (int j = 0; j < cwr_pkg::ND_PER; j++) begin
      f    = first_stage && (j == 0);
      bx   = div_bit(b.rx, b.den, f);
      by   = div_bit(b.ry, b.den, f);
      b.rx = bx[cwr_pkg::ROOT_W-1:0];
      b.ry = by[cwr_pkg::ROOT_W-1:0];
      b.qx = {b.qx[cwr_pkg::NQ_BITS-2:0], bx[cwr_pkg::ROOT_W]};
      b.qy = {b.qy[cwr_pkg::NQ_BITS-2:0], by[cwr_pkg::ROOT_W]};
    end
    return b;
  endfunction

  logic           v_r    [cwr_pkg::ND_STAGES];
  nd_stage_t      st_r   [cwr_pkg::ND_STAGES];
  cwr_pkg::side_t side_r [cwr_pkg::ND_STAGES];
  nd_stage_t      st_nxt [cwr_pkg::ND_STAGES];
  nd_stage_t      st_in0;
  logic [cwr_pkg::NQ_BITS:0] rx_sum;
  logic [cwr_pkg::NQ_BITS:0] ry_sum;

  assign st_in0 = '{den: den_i,
                    rx:  cwr_pkg::mag_diff(side_i.dx),
                    ry:  cwr_pkg::mag_diff(side_i.dy),
                    qx:  '0,
                    qy:  '0};

  always_comb begin
    st_nxt[0] = nd_stage(st_in0, 1'b1);
    for (int s = 1; s < cwr_pkg::ND_STAGES; s++) begin
      st_nxt[s] = nd_stage(st_r[s-1], 1'b0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < cwr_pkg::ND_STAGES; s++) v_r[s] <= 1'b0;
    end else if (en) begin
      v_r[0] <= v_i;
      for (int s = 1; s < cwr_pkg::ND_STAGES; s++) v_r[s] <= v_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_i;
      for (int s = 1; s < cwr_pkg::ND_STAGES; s++) side_r[s] <= side_r[s-1];
      for (int s = 0; s < cwr_pkg::ND_STAGES; s++) st_r[s] <= st_nxt[s];
    end
  end

  // Round half up on the extra quotient bit.
  assign rx_sum = {1'b0, st_r[cwr_pkg::ND_STAGES-1].qx} + 1'b1;
  assign ry_sum = {1'b0, st_r[cwr_pkg::ND_STAGES-1].qy} + 1'b1;
  assign nxm_o  = rx_sum[cwr_pkg::NRM_W:1];
  assign nym_o  = ry_sum[cwr_pkg::NRM_W:1];
  assign v_o    = v_r[cwr_pkg::ND_STAGES-1];
  assign side_o = side_r[cwr_pkg::ND_STAGES-1];

endmodule
`default_nettype wire

@@ sv/circular_wall_reflection_unit.sv @@
// Circular wall reflection unit, top level; uses cwr_pkg, cwr_isqrt, cwr_ndiv and the
// assertion macros header. One request is one particle (position, velocity, Q16.16).
// The block takes one request per clock while in_stall is low and returns one result per
// request, in order. A request passes four front stages, the 11-stage square root
// (3 root bits per stage), the 6-stage normal divider (3 quotient bits per stage),
// five multiply/round stages and the output register. The whole pipeline advances
// together: it holds while a result waits in the output register under stall, so
// in_stall follows out_stall in that case. Wall radius and centre are written through the
// cfg port (always ready) and must only change while no request is in flight. A particle
// strictly outside the wall gets its velocity reflected about the normal and its position
// pulled back by the overlap, with hit_wall set; all other particles pass through
// unchanged.
`default_nettype none
`include "circular_wall_reflection_unit_defines.svh"
module circular_wall_reflection_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  cwr_pkg::in_t                        in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output cwr_pkg::out_t                       out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cwr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cwr_pkg::DW-1:0]              cfg_data
);

  // ---------------------------------------------------------------- config
  logic [cwr_pkg::RAD_W-1:0] wall_radius_r;
  cwr_pkg::dw_t              wall_center_x_r;
  cwr_pkg::dw_t              wall_center_y_r;

  assign cfg_ready = 1'b1;

  // Drop writes to indexes beyond the register list.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wall_radius_r   <= '0;
      wall_center_x_r <= '0;
      wall_center_y_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cwr_pkg::cfg_idx_t'(cfg_index))
        cwr_pkg::CFG_WALL_RADIUS:   wall_radius_r   <= cfg_data[cwr_pkg::RAD_W-1:0];
        cwr_pkg::CFG_WALL_CENTER_X: wall_center_x_r <= cfg_data;
        cwr_pkg::CFG_WALL_CENTER_Y: wall_center_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow
  // Advance every stage when the output register is free or being taken.
  logic out_valid_r;
  logic en;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // ---------------------------------------------------------------- stage A
  // Offset from the centre, exact in DW+1 bits.
  logic           v_a_r;
  cwr_pkg::side_t a_r;
  cwr_pkg::side_t a_nxt;

  always_comb begin
    a_nxt      = '0;
    a_nxt.data = in_data;
    a_nxt.dx   = cwr_pkg::diff_t'(in_data.pos_x) - cwr_pkg::diff_t'(wall_center_x_r);
    a_nxt.dy   = cwr_pkg::diff_t'(in_data.pos_y) - cwr_pkg::diff_t'(wall_center_y_r);
  end

  // ---------------------------------------------------------------- stage B
  // Square both offsets and the radius.
  logic           v_b_r;
  cwr_pkg::side_t b_r;
  cwr_pkg::sq_t   sqx_b_r;
  cwr_pkg::sq_t   sqy_b_r;
  cwr_pkg::sq_t   r2_b_r;
  cwr_pkg::root_t mdx_a;
  cwr_pkg::root_t mdy_a;

  assign mdx_a = cwr_pkg::mag_diff(a_r.dx);
  assign mdy_a = cwr_pkg::mag_diff(a_r.dy);

  // ---------------------------------------------------------------- stage C
  logic           v_c_r;
  cwr_pkg::side_t c_r;
  cwr_pkg::sq_t   d2_c_r;
  cwr_pkg::sq_t   r2_c_r;

  // ---------------------------------------------------------------- stage D
  // Strict compare: a particle exactly on the wall is not a hit.
  logic           v_d_r;
  cwr_pkg::side_t d_r;
  cwr_pkg::sq_t   d2_d_r;
  cwr_pkg::side_t d_nxt;

  always_comb begin
    d_nxt     = c_r;
    d_nxt.hit = d2_c_r > r2_c_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
      v_d_r <= 1'b0;
    end else if (en) begin
      v_a_r <= in_valid;
      v_b_r <= v_a_r;
      v_c_r <= v_b_r;
      v_d_r <= v_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r     <= a_nxt;
      b_r     <= a_r;
      sqx_b_r <= cwr_pkg::sq_t'(mdx_a) * cwr_pkg::sq_t'(mdx_a);
      sqy_b_r <= cwr_pkg::sq_t'(mdy_a) * cwr_pkg::sq_t'(mdy_a);
      r2_b_r  <= cwr_pkg::sq_t'(wall_radius_r) * cwr_pkg::sq_t'(wall_radius_r);
      c_r     <= b_r;
      d2_c_r  <= sqx_b_r + sqy_b_r;
      r2_c_r  <= r2_b_r;
      d_r     <= d_nxt;
      d2_d_r  <= d2_c_r;
    end
  end

  // ---------------------------------------------------------------- sqrt
  logic           v_s;
  cwr_pkg::root_t root_s;
  cwr_pkg::side_t side_s;
  cwr_pkg::side_t side_s_ovl;

  cwr_isqrt u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .v_i    (v_d_r),
    .rad_i  (d2_d_r),
    .side_i (d_r),
    .v_o    (v_s),
    .root_o (root_s),
    .side_o (side_s)
  );

  // Overlap past the wall; never negative on a hit since floor(|d|) >= radius.
  always_comb begin
    side_s_ovl     = side_s;
    side_s_ovl.ovl = root_s - {{(cwr_pkg::ROOT_W - cwr_pkg::RAD_W){1'b0}}, wall_radius_r};
  end

  // ---------------------------------------------------------------- normal
  logic           v_n;
  cwr_pkg::nrm_t  nxm_n;
  cwr_pkg::nrm_t  nym_n;
  cwr_pkg::side_t side_n;

  cwr_ndiv u_ndiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .v_i    (v_s),
    .den_i  (root_s),
    .side_i (side_s_ovl),
    .v_o    (v_n),
    .nxm_o  (nxm_n),
    .nym_o  (nym_n),
    .side_o (side_n)
  );

  // ---------------------------------------------------------------- M1
  // Magnitude products for v.n and overlap*n; signs ride along.
  logic           v_m1_r;
  cwr_pkg::side_t m1_r;
  cwr_pkg::nrm_t  nxm_m1_r;
  cwr_pkg::nrm_t  nym_m1_r;
  cwr_pkg::prod_t pvx_m1_r;
  cwr_pkg::prod_t pvy_m1_r;
  cwr_pkg::prod_t pox_m1_r;
  cwr_pkg::prod_t poy_m1_r;
  logic [cwr_pkg::DW-1:0] mvx_n;
  logic [cwr_pkg::DW-1:0] mvy_n;

  assign mvx_n = cwr_pkg::mag_dw(side_n.data.vel_x);
  assign mvy_n = cwr_pkg::mag_dw(side_n.data.vel_y);

  // ---------------------------------------------------------------- M2
  // Round the products to signed terms at Q16.16 scale (16 fraction bits, wider integer part).
  logic           v_m2_r;
  cwr_pkg::side_t m2_r;
  cwr_pkg::nrm_t  nxm_m2_r;
  cwr_pkg::nrm_t  nym_m2_r;
  cwr_pkg::term_t tvx_m2_r;
  cwr_pkg::term_t tvy_m2_r;
  cwr_pkg::term_t tox_m2_r;
  cwr_pkg::term_t toy_m2_r;
  logic sx_m1;
  logic sy_m1;

  assign sx_m1 = m1_r.dx[cwr_pkg::DIFF_W-1];
  assign sy_m1 = m1_r.dy[cwr_pkg::DIFF_W-1];

  // ---------------------------------------------------------------- M3
  // Form 2*dot as magnitude and sign; finish the corrected position.
  logic           v_m3_r;
  cwr_pkg::side_t m3_r;
  cwr_pkg::nrm_t  nxm_m3_r;
  cwr_pkg::nrm_t  nym_m3_r;
  logic [cwr_pkg::DIFF_W:0] dm2_m3_r;
  logic           dneg_m3_r;
  cwr_pkg::dw_t   npx_m3_r;
  cwr_pkg::dw_t   npy_m3_r;
  cwr_pkg::acc_t  dot_m2;
  logic [cwr_pkg::ACC_W-1:0] dmag_m2;

  assign dot_m2  = cwr_pkg::acc_t'(tvx_m2_r) + cwr_pkg::acc_t'(tvy_m2_r);
  assign dmag_m2 = cwr_pkg::mag_acc(dot_m2);

  // ---------------------------------------------------------------- M4
  logic           v_m4_r;
  cwr_pkg::side_t m4_r;
  logic           dneg_m4_r;
  cwr_pkg::dw_t   npx_m4_r;
  cwr_pkg::dw_t   npy_m4_r;
  cwr_pkg::prod_t pdx_m4_r;
  cwr_pkg::prod_t pdy_m4_r;

  // ---------------------------------------------------------------- M5
  logic           v_m5_r;
  cwr_pkg::side_t m5_r;
  cwr_pkg::dw_t   npx_m5_r;
  cwr_pkg::dw_t   npy_m5_r;
  cwr_pkg::term_t tdx_m5_r;
  cwr_pkg::term_t tdy_m5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_m1_r <= 1'b0;
      v_m2_r <= 1'b0;
      v_m3_r <= 1'b0;
      v_m4_r <= 1'b0;
      v_m5_r <= 1'b0;
    end else if (en) begin
      v_m1_r <= v_n;
      v_m2_r <= v_m1_r;
      v_m3_r <= v_m2_r;
      v_m4_r <= v_m3_r;
      v_m5_r <= v_m4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // M1
      m1_r     <= side_n;
      nxm_m1_r <= nxm_n;
      nym_m1_r <= nym_n;
      pvx_m1_r <= cwr_pkg::prod_t'(mvx_n) * cwr_pkg::prod_t'(nxm_n);
      pvy_m1_r <= cwr_pkg::prod_t'(mvy_n) * cwr_pkg::prod_t'(nym_n);
      pox_m1_r <= cwr_pkg::prod_t'(side_n.ovl) * cwr_pkg::prod_t'(nxm_n);
      poy_m1_r <= cwr_pkg::prod_t'(side_n.ovl) * cwr_pkg::prod_t'(nym_n);
      // M2
      m2_r     <= m1_r;
      nxm_m2_r <= nxm_m1_r;
      nym_m2_r <= nym_m1_r;
      tvx_m2_r <= cwr_pkg::rnd_term(pvx_m1_r, m1_r.data.vel_x[cwr_pkg::DW-1] ^ sx_m1);
      tvy_m2_r <= cwr_pkg::rnd_term(pvy_m1_r, m1_r.data.vel_y[cwr_pkg::DW-1] ^ sy_m1);
      tox_m2_r <= cwr_pkg::rnd_term(pox_m1_r, sx_m1);
      toy_m2_r <= cwr_pkg::rnd_term(poy_m1_r, sy_m1);
      // M3
      m3_r      <= m2_r;
      nxm_m3_r  <= nxm_m2_r;
      nym_m3_r  <= nym_m2_r;
      dm2_m3_r  <= {dmag_m2[cwr_pkg::DIFF_W-1:0], 1'b0};
      dneg_m3_r <= dot_m2[cwr_pkg::ACC_W-1];
      npx_m3_r  <= cwr_pkg::sat_dw(cwr_pkg::acc_t'(m2_r.data.pos_x)
                                   - cwr_pkg::acc_t'(tox_m2_r));
      npy_m3_r  <= cwr_pkg::sat_dw(cwr_pkg::acc_t'(m2_r.data.pos_y)
                                   - cwr_pkg::acc_t'(toy_m2_r));
      // M4
      m4_r      <= m3_r;
      dneg_m4_r <= dneg_m3_r;
      npx_m4_r  <= npx_m3_r;
      npy_m4_r  <= npy_m3_r;
      pdx_m4_r  <= cwr_pkg::prod_t'(dm2_m3_r) * cwr_pkg::prod_t'(nxm_m3_r);
      pdy_m4_r  <= cwr_pkg::prod_t'(dm2_m3_r) * cwr_pkg::prod_t'(nym_m3_r);
      // M5
      m5_r     <= m4_r;
      npx_m5_r <= npx_m4_r;
      npy_m5_r <= npy_m4_r;
      tdx_m5_r <= cwr_pkg::rnd_term(pdx_m4_r, dneg_m4_r ^ m4_r.dx[cwr_pkg::DIFF_W-1]);
      tdy_m5_r <= cwr_pkg::rnd_term(pdy_m4_r, dneg_m4_r ^ m4_r.dy[cwr_pkg::DIFF_W-1]);
    end
  end

  // ---------------------------------------------------------------- output
  // Pick reflected or pass-through values; hold under stall.
  cwr_pkg::out_t out_r;
  cwr_pkg::out_t out_nxt;

  always_comb begin
    if (m5_r.hit) begin
      out_nxt.new_pos_x = npx_m5_r;
      out_nxt.new_pos_y = npy_m5_r;
      out_nxt.new_vel_x = cwr_pkg::sat_dw(cwr_pkg::acc_t'(m5_r.data.vel_x)
                                          - cwr_pkg::acc_t'(tdx_m5_r));
      out_nxt.new_vel_y = cwr_pkg::sat_dw(cwr_pkg::acc_t'(m5_r.data.vel_y)
                                          - cwr_pkg::acc_t'(tdy_m5_r));
      out_nxt.hit_wall  = 1'b1;
    end else begin
      out_nxt.new_pos_x = m5_r.data.pos_x;
      out_nxt.new_pos_y = m5_r.data.pos_y;
      out_nxt.new_vel_x = m5_r.data.vel_x;
      out_nxt.new_vel_y = m5_r.data.vel_y;
      out_nxt.hit_wall  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_m5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------------------------------------------------------- checks
  `CWR_ASSERT_NEXT(a_hold_on_stall, !en, $stable(v_m5_r) && $stable(v_n))
  `CWR_ASSERT_NEXT(a_last_stage_drains, en && v_m5_r, out_valid_r)
  `CWR_ASSERT_IMPL(a_normal_bound, v_n && side_n.hit, (nxm_n <= cwr_pkg::NRM_ONE) && (nym_n <= cwr_pkg::NRM_ONE))

endmodule
`default_nettype wire
